/* rtl/svpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svpp_pkg;

  localparam int MUL_W = 16;
  localparam int DVD_W = 32;
  localparam int DEN_W = 17;

  localparam logic [15:0] DEAD_BAND = 16'd10;
  localparam logic [15:0] PULSE_CAP = 16'hFFFF;
  localparam logic [7:0]  ANGLE_CAP = 8'hFF;
  localparam logic [3:0]  TENS_CAP  = 4'd9;
  localparam logic [6:0]  SEG_ZERO  = 7'h3F;

  localparam logic [2:0] REG_MIN_PULSE     = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE     = 3'd1;
  localparam logic [2:0] REG_MID_PULSE     = 3'd2;
  localparam logic [2:0] REG_ANGLE_FULL    = 3'd3;
  localparam logic [2:0] REG_FULL_SCALE    = 3'd4;
  localparam logic [2:0] REG_PICKUP_WINDOW = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_DIV_T,
    ST_UPD,
    ST_ANG,
    ST_MUL_A,
    ST_DIV_A,
    ST_OUT
  } state_t;

  // x / 10 for 8-bit x
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = {8'b0, x} * 16'd205;
    return p[15:11];
  endfunction

  // gfedcba
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = SEG_ZERO;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/svpp_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module svpp_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0]    product,
  output logic                  done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]     a_reg;
  logic [A_W:0]       hi;
  logic [B_W-1:0]     lo;
  logic [CNT_W-1:0]   cnt;
  logic [A_W:0]       hi_sum;
  logic [A_W+B_W:0]   shifted;

  always_comb begin
    hi_sum  = hi + (lo[0] ? {1'b0, a_reg} : '0);
    shifted = {hi_sum, lo} >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
    end else if (cnt != '0) begin
      hi <= shifted[A_W+B_W:B_W];
      lo <= shifted[B_W-1:0];
    end
  end

  assign product = {hi[A_W-1:0], lo};

endmodule

`default_nettype wire

/* rtl/svpp_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module svpp_div #(
  parameter int N_W = 32,
  parameter int D_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [N_W-1:0]   dividend,
  input  wire logic [D_W-1:0]   divisor,
  output logic [N_W-1:0]        quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   dvd;
  logic [D_W-1:0]   den;
  logic [D_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     trial;
  logic             qbit;

  always_comb begin
    rem_sh = {rem, dvd[N_W-1]};
    trial  = rem_sh - {1'b0, den};
    qbit   = ~trial[D_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(N_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[N_W-2:0], qbit};
      rem <= qbit ? trial[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

/* rtl/servo_pulse_from_pot_with_pickup.sv */
`timescale 1ns / 1ps
`default_nettype none

// Servo pulse from potentiometer samples, with knob pickup.
// Input channel (in_valid/in_ready): one converter sample and a servo select
// per transfer. A sample that does not complete a block of SAMPLES is added
// to the sum and count while in_ready stays high. The sample that completes
// a block starts a shift-add multiply and a radix-2 divide for the target,
// the pulse update, then a second multiply and divide for the angle, which
// are skipped when the pulse sits in the dead band or the span is not
// positive; in_ready stays low meanwhile.
// Output channel (out_valid/out_ready): one result per full block, held in an
// output register. While it waits, further samples are still taken; a new
// block result waits in the final step until the register frees.
// Config channel (cfg_valid/cfg_ready): always ready; must be written only
// while idle, which the block does not enforce. Reset (rst, synchronous):
// defaults load; sum, count, stored pulses clear; display starts on ones.
module servo_pulse_from_pot_with_pickup #(
  parameter int SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] pot_code,
  input  wire logic        servo_select,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             servo_channel,
  output logic [15:0]      pulse_width,
  output logic [7:0]       angle_value,
  output logic [6:0]       segment_bits,
  output logic             digit_position,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CW    = $clog2(SAMPLES + 1);
  localparam int MUL_W = svpp_pkg::MUL_W;
  localparam int DVD_W = svpp_pkg::DVD_W;
  localparam int DEN_W = svpp_pkg::DEN_W;

  svpp_pkg::state_t state, state_next;

  logic [15:0] min_pulse, max_pulse, mid_pulse, pickup_window;
  logic [7:0]  angle_full;
  logic [11:0] full_scale;

  logic [CW-1:0] count;
  logic [15:0]   sum, sum_next;
  logic          fill, in_xfer, out_free;
  logic          sel;
  logic [15:0]   target, pulse, profile_pulse, flap_pulse;
  logic [7:0]    angle;
  logic          show_ones;

  logic                   mul_start, mul_done;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     mul_prod;
  logic                   div_start, div_done;
  logic [DEN_W-1:0]       div_den;
  logic [DVD_W-1:0]       div_q;

  logic [11:0]  fs_eff;
  logic [DEN_W-1:0] block_den;
  logic [32:0]  t_sum;
  logic [15:0]  stored, delta, upd0, upd1, upd;
  logic         take;
  logic [16:0]  mid_hi;
  logic         above, below, outside, span_pos, ang_mul;
  logic [15:0]  diff, span;
  logic [4:0]   tens;
  logic [3:0]   ones_w;
  logic [3:0]   tens_sat;
  logic         show_next;

  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign fill      = (count == CW'(SAMPLES - 1));
  assign sum_next  = sum + {4'b0, pot_code};

  assign fs_eff    = (full_scale == '0) ? 12'd1 : full_scale;
  assign block_den = DEN_W'(SAMPLES) * {5'b0, fs_eff};
  assign t_sum     = {1'b0, div_q} + {17'b0, min_pulse};

  // pickup and clamp
  always_comb begin
    stored = sel ? profile_pulse : flap_pulse;
    delta  = (stored > target) ? stored - target : target - stored;
    take   = (stored == '0) || (delta < pickup_window);
    upd0   = take ? target : stored;
    upd1   = (upd0 < min_pulse) ? min_pulse : upd0;
    upd    = (upd1 > max_pulse) ? max_pulse : upd1;
  end

  // dead band and span
  always_comb begin
    mid_hi   = {1'b0, mid_pulse} + {1'b0, svpp_pkg::DEAD_BAND};
    above    = {1'b0, pulse} > mid_hi;
    below    = (mid_pulse >= svpp_pkg::DEAD_BAND) &&
               (pulse < mid_pulse - svpp_pkg::DEAD_BAND);
    outside  = above || below;
    diff     = above ? pulse - mid_pulse : mid_pulse - pulse;
    span_pos = mid_pulse > min_pulse;
    span     = mid_pulse - min_pulse;
    ang_mul  = outside && span_pos;
  end

  // display digit
  always_comb begin
    show_next = ~show_ones;
    tens      = svpp_pkg::div10(angle);
    ones_w    = 4'(angle - 8'({3'b0, tens} * 8'd10));
    tens_sat  = (tens > 5'(svpp_pkg::TENS_CAP)) ? svpp_pkg::TENS_CAP : tens[3:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      svpp_pkg::ST_IDLE:  if (in_xfer && fill) state_next = svpp_pkg::ST_MUL_T;
      svpp_pkg::ST_MUL_T: if (mul_done) state_next = svpp_pkg::ST_DIV_T;
      svpp_pkg::ST_DIV_T: if (div_done) state_next = svpp_pkg::ST_UPD;
      svpp_pkg::ST_UPD:   state_next = svpp_pkg::ST_ANG;
      svpp_pkg::ST_ANG:   state_next = ang_mul ? svpp_pkg::ST_MUL_A : svpp_pkg::ST_OUT;
      svpp_pkg::ST_MUL_A: if (mul_done) state_next = svpp_pkg::ST_DIV_A;
      svpp_pkg::ST_DIV_A: if (div_done) state_next = svpp_pkg::ST_OUT;
      svpp_pkg::ST_OUT:   if (out_free) state_next = svpp_pkg::ST_IDLE;
      default:            state_next = svpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = sum_next;
    mul_b     = min_pulse;
    div_start = 1'b0;
    div_den   = block_den;
    unique case (state)
      svpp_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mul_start = in_xfer && fill;
      end
      svpp_pkg::ST_MUL_T: begin
        div_start = mul_done;
      end
      svpp_pkg::ST_ANG: begin
        mul_start = ang_mul;
        mul_a     = diff;
        mul_b     = {8'b0, angle_full};
      end
      svpp_pkg::ST_MUL_A: begin
        div_start = mul_done;
        div_den   = {1'b0, span};
      end
      default: begin
      end
    endcase
  end

  svpp_mul #(
    .A_W(MUL_W),
    .B_W(MUL_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .done    (mul_done)
  );

  svpp_div #(
    .N_W(DVD_W),
    .D_W(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= svpp_pkg::ST_IDLE;
      min_pulse     <= 16'd1000;
      max_pulse     <= 16'd2000;
      mid_pulse     <= 16'd1500;
      angle_full    <= 8'd90;
      full_scale    <= 12'd4095;
      pickup_window <= 16'd100;
      count         <= '0;
      sum           <= '0;
      profile_pulse <= '0;
      flap_pulse    <= '0;
      show_ones     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          svpp_pkg::REG_MIN_PULSE:     min_pulse     <= cfg_data;
          svpp_pkg::REG_MAX_PULSE:     max_pulse     <= cfg_data;
          svpp_pkg::REG_MID_PULSE:     mid_pulse     <= cfg_data;
          svpp_pkg::REG_ANGLE_FULL:    angle_full    <= cfg_data[7:0];
          svpp_pkg::REG_FULL_SCALE:    full_scale    <= cfg_data[11:0];
          svpp_pkg::REG_PICKUP_WINDOW: pickup_window <= cfg_data;
          default: begin
          end
        endcase
      end

      if (in_xfer) begin
        if (fill) begin
          count <= '0;
          sum   <= '0;
        end else begin
          count <= count + 1'b1;
          sum   <= sum_next;
        end
      end

      if (state == svpp_pkg::ST_UPD) begin
        if (sel) begin
          profile_pulse <= upd;
        end else begin
          flap_pulse <= upd;
        end
      end

      if (state == svpp_pkg::ST_OUT && out_free) begin
        show_ones <= show_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && fill) begin
      sel <= servo_select;
    end
    if (state == svpp_pkg::ST_DIV_T && div_done) begin
      target <= (t_sum[32:16] != '0) ? svpp_pkg::PULSE_CAP : t_sum[15:0];
    end
    if (state == svpp_pkg::ST_UPD) begin
      pulse <= upd;
    end
    if (state == svpp_pkg::ST_ANG && !ang_mul) begin
      angle <= outside ? svpp_pkg::ANGLE_CAP : 8'd0;
    end
    if (state == svpp_pkg::ST_DIV_A && div_done) begin
      angle <= (div_q[DVD_W-1:8] != '0) ? svpp_pkg::ANGLE_CAP : div_q[7:0];
    end
    if (state == svpp_pkg::ST_OUT && out_free) begin
      servo_channel  <= sel;
      pulse_width    <= pulse;
      angle_value    <= angle;
      digit_position <= ~show_next;
      segment_bits   <= svpp_pkg::seg_of(show_next ? ones_w : tens_sat);
    end
  end

endmodule

`default_nettype wire

/* rtl/svpp_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module svpp_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        servo_channel,
  input wire logic [15:0] pulse_width,
  input wire logic [7:0]  angle_value,
  input wire logic [6:0]  segment_bits,
  input wire logic        digit_position
);

  logic last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos <= 1'b1;
    end else if (out_valid && out_ready) begin
      last_pos <= digit_position;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_width) &&
      $stable(angle_value) && $stable(segment_bits) && $stable(servo_channel))
    else $error("output changed while stalled");

  a_digit_alt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> digit_position != last_pos)
    else $error("digit position did not alternate");

  a_zero_seg: assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_value == 8'd0 |-> segment_bits == svpp_pkg::SEG_ZERO)
    else $error("zero angle shows nonzero digit");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without a transfer");

endmodule

bind servo_pulse_from_pot_with_pickup svpp_chk u_svpp_chk (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLES_PER_BLOCK = 16;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 800;
  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] DIGIT_BASE = 8'd10;
  localparam logic [6:0] DIGIT_SEGS [0:9] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
  };

  typedef struct packed {
    logic [11:0] adc;
    logic        sel;
  } pot_sample_t;

  typedef struct packed {
    logic        chan;
    logic [15:0] pulse;
    logic [7:0]  angle;
    logic [6:0]  seg;
    logic        pos;
  } servo_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] pot_code = 12'd0;
  logic        servo_select = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        servo_channel;
  logic [15:0] pulse_width;
  logic [7:0]  angle_value;
  logic [6:0]  segment_bits;
  logic        digit_position;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = svpp_pkg::REG_MIN_PULSE;
  logic [15:0] cfg_data = 16'd0;

  pot_sample_t   pot_q [$];
  servo_result_t expected_servo_q [$];
  pot_sample_t   next_pot;

  // predictor copy of registers and state
  logic [15:0] cfg_min = 16'd1000;
  logic [15:0] cfg_max = 16'd2000;
  logic [15:0] cfg_mid = 16'd1500;
  logic [7:0]  cfg_angle_full = 8'd90;
  logic [11:0] cfg_fs = 12'd4095;
  logic [15:0] cfg_pickup = 16'd100;
  logic [4:0]  acc_count = 5'd0;
  logic [15:0] acc_sum = 16'd0;
  logic [15:0] profile_stored = 16'd0;
  logic [15:0] flap_stored = 16'd0;
  logic        ones_shown = 1'b0;

  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic sink_hold = 1'b0;
  int mismatch_count = 0;
  int fill_count = 0;
  int knob [2] = '{2000, 2000};

  servo_pulse_from_pot_with_pickup #(
    .SAMPLES(SAMPLES_PER_BLOCK)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pot_code(pot_code),
    .servo_select(servo_select),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .servo_channel(servo_channel),
    .pulse_width(pulse_width),
    .angle_value(angle_value),
    .segment_bits(segment_bits),
    .digit_position(digit_position),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] pickup_pulse(input logic [15:0] stored,
                                               input logic [15:0] tgt);
    logic [15:0] delta;
    logic [15:0] p;
    delta = (stored > tgt) ? stored - tgt : tgt - stored;
    p = stored;
    if (stored == 16'd0 || delta < cfg_pickup) p = tgt;
    if (p < cfg_min) p = cfg_min;
    if (p > cfg_max) p = cfg_max;
    return p;
  endfunction

  function automatic logic [7:0] angle_of_pulse(input logic [15:0] p);
    logic [15:0] diff;
    logic [31:0] q;
    if ({1'b0, p} > {1'b0, cfg_mid} + {1'b0, svpp_pkg::DEAD_BAND}) begin
      diff = p - cfg_mid;
    end else if (cfg_mid >= svpp_pkg::DEAD_BAND && p < cfg_mid - svpp_pkg::DEAD_BAND) begin
      diff = cfg_mid - p;
    end else begin
      return 8'd0;
    end
    if (cfg_mid <= cfg_min) return svpp_pkg::ANGLE_CAP;
    q = (32'(diff) * 32'(cfg_angle_full)) / 32'(cfg_mid - cfg_min);
    return (q > 32'(svpp_pkg::ANGLE_CAP)) ? svpp_pkg::ANGLE_CAP : q[7:0];
  endfunction

  task automatic predict_servo_sample(input logic [11:0] adc, input logic sel);
    logic [47:0]   tgt;
    logic [11:0]   fs;
    logic [15:0]   pulse;
    logic [7:0]    ang;
    logic [7:0]    tens;
    logic [3:0]    digit;
    servo_result_t r;
    acc_sum = acc_sum + 16'(adc);
    acc_count = acc_count + 5'd1;
    if (acc_count < SAMPLES_PER_BLOCK) return;
    fs = (cfg_fs == 12'd0) ? 12'd1 : cfg_fs;
    tgt = (48'(acc_sum) * 48'(cfg_min)) / (48'(SAMPLES_PER_BLOCK) * 48'(fs))
          + 48'(cfg_min);
    if (tgt > 48'(svpp_pkg::PULSE_CAP)) tgt = 48'(svpp_pkg::PULSE_CAP);
    acc_count = 5'd0;
    acc_sum = 16'd0;
    if (sel) begin
      profile_stored = pickup_pulse(profile_stored, tgt[15:0]);
      pulse = profile_stored;
    end else begin
      flap_stored = pickup_pulse(flap_stored, tgt[15:0]);
      pulse = flap_stored;
    end
    ang = angle_of_pulse(pulse);
    ones_shown = ~ones_shown;
    if (ones_shown) begin
      digit = 4'(ang % DIGIT_BASE);
      r.pos = 1'b0;
    end else begin
      tens = ang / DIGIT_BASE;
      digit = (tens > 8'(svpp_pkg::TENS_CAP)) ? svpp_pkg::TENS_CAP : tens[3:0];
      r.pos = 1'b1;
    end
    r.chan = sel;
    r.pulse = pulse;
    r.angle = ang;
    r.seg = DIGIT_SEGS[digit];
    expected_servo_q.push_back(r);
  endtask

  // sample source
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pot_q.size() != 0) begin
        next_pot = pot_q.pop_front();
        pot_code <= next_pot.adc;
        servo_select <= next_pot.sel;
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap = recv_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check result transfers, predict on sample transfers
  always @(posedge clk) begin
    servo_result_t got;
    servo_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{servo_channel, pulse_width, angle_value, segment_bits, digit_position};
        if (expected_servo_q.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected result ch=%0d pulse=%0d angle=%0d seg=%02h pos=%0d",
                     $realtime, got.chan, got.pulse, got.angle, got.seg, got.pos);
          mismatch_count++;
        end else begin
          want = expected_servo_q.pop_front();
          if (got.chan !== want.chan || got.pulse !== want.pulse ||
              got.angle !== want.angle || got.seg !== want.seg || got.pos !== want.pos) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: mismatch: want ch=%0d pulse=%0d angle=%0d seg=%02h pos=%0d",
                       $realtime, want.chan, want.pulse, want.angle, want.seg, want.pos);
              $display("%0t:            got ch=%0d pulse=%0d angle=%0d seg=%02h pos=%0d",
                       $realtime, got.chan, got.pulse, got.angle, got.seg, got.pos);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_servo_sample(pot_code, servo_select);
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pot_q.size() != 0 || in_valid || expected_servo_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      svpp_pkg::REG_MIN_PULSE:     cfg_min = val;
      svpp_pkg::REG_MAX_PULSE:     cfg_max = val;
      svpp_pkg::REG_MID_PULSE:     cfg_mid = val;
      svpp_pkg::REG_ANGLE_FULL:    cfg_angle_full = val[7:0];
      svpp_pkg::REG_FULL_SCALE:    cfg_fs = val[11:0];
      svpp_pkg::REG_PICKUP_WINDOW: cfg_pickup = val;
      default: ;
    endcase
  endtask

  function automatic void push_pot(input int adc, input logic sel);
    int v;
    v = (adc < 0) ? 0 : (adc > 4095) ? 4095 : adc;
    pot_q.push_back('{adc: v[11:0], sel: sel});
    fill_count = (fill_count + 1) % SAMPLES_PER_BLOCK;
  endfunction

  // mostly whole blocks around a slowly moving knob, some raw noise
  function automatic void queue_pot_items(input int count);
    int pushed;
    int n;
    int k;
    logic sel;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 7) begin
        sel = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) knob[sel] = $urandom_range(0, 4095);
        else knob[sel] = knob[sel] + $urandom_range(0, 60) - 30;
        if (knob[sel] < 0) knob[sel] = 0;
        if (knob[sel] > 4095) knob[sel] = 4095;
        n = SAMPLES_PER_BLOCK - fill_count;
        for (k = 0; k < n; k++) begin
          push_pot(knob[sel] + $urandom_range(0, 40) - 20,
                   (k == n - 1 || $urandom_range(0, 3) != 0) ? sel : ~sel);
        end
      end else begin
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++) push_pot($urandom_range(0, 4095), 1'($urandom_range(0, 1)));
      end
      pushed += n;
    end
  endfunction

  task automatic run_phase(input logic [15:0] min_p, input logic [15:0] max_p,
                           input logic [15:0] mid_p, input logic [15:0] af,
                           input logic [15:0] fs, input logic [15:0] pw,
                           input int count, input int send_pct, input int recv_pct);
    wait_idle();
    write_reg(svpp_pkg::REG_MIN_PULSE, min_p);
    write_reg(svpp_pkg::REG_MAX_PULSE, max_p);
    write_reg(svpp_pkg::REG_MID_PULSE, mid_p);
    write_reg(svpp_pkg::REG_ANGLE_FULL, af);
    write_reg(svpp_pkg::REG_FULL_SCALE, fs);
    write_reg(svpp_pkg::REG_PICKUP_WINDOW, pw);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_pot_items(count);
  endtask

  initial begin
    int i;
    logic [15:0] lo;
    logic [15:0] hi;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // full-scale block on the profile channel, then a partial flap block
    for (i = 0; i < SAMPLES_PER_BLOCK; i++) push_pot(4095, i[0]);
    push_pot(4095, 1'b1);
    for (i = 0; i < 8; i++) push_pot(0, 1'b0);

    run_phase(16'd1000, 16'd2000, 16'd1500, 16'd90, 16'd4095, 16'd100, 96, 30, 30);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd4095, 16'hFFFF, 64, 25, 25);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 64, 25, 25);
    run_phase(16'd3000, 16'd1200, 16'd2000, 16'd200, 16'd1, 16'd0, 64, 40, 10);
    run_phase(16'd1500, 16'd3000, 16'd1200, 16'd90, 16'd4095, 16'd500, 64, 10, 40);

    // long sink stall while samples keep coming
    run_phase(16'd1000, 16'd2000, 16'd1500, 16'd90, 16'd4095, 16'd100, 160, 5, 10);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none

    for (i = 0; i < 4; i++) begin
      lo = 16'($urandom_range(500, 1500));
      hi = lo + 16'($urandom_range(0, 2000));
      run_phase(lo, hi, lo + 16'($urandom_range(0, 1500)), 16'($urandom),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 400)),
                64, $urandom_range(0, 40), $urandom_range(0, 40));
    end
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 64, 20, 20);

    run_phase(16'd1000, 16'd2000, 16'd1500, 16'd90, 16'd4095, 16'd100, 80, 0, 0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
